@@ rtl/core/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// Slot table package
// Shared types, command and status codes, and default sizes for the slot
// table with compaction.
// ----------------------------------------------------------------------------
package stc_pkg;

    localparam int SLOTS_DEF      = 8;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int QUEUE_DEPTH    = 2;

    // Command codes on the input beat.
    localparam logic [1:0] CMD_INSERT  = 2'd0;
    localparam logic [1:0] CMD_DELETE  = 2'd1;
    localparam logic [1:0] CMD_COMPACT = 2'd2;
    localparam logic [1:0] CMD_NONE    = 2'd3;

    // Status codes on the result beat.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_BAD_POS = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
        logic [3:0]         position;
    } t_cmd;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] removed_value;
        logic [3:0]         slot_used;
        logic [3:0]         occupied_count;
    } t_result;

    // Operation class decided by the front end.
    typedef enum logic [2:0] {
        OP_INSERT,
        OP_INSERT_ZERO,
        OP_DELETE,
        OP_BAD_POS,
        OP_COMPACT,
        OP_NOP
    } t_op_kind;

    typedef struct packed {
        t_op_kind           kind;
        logic signed [31:0] value;
        logic [3:0]         position;
    } t_op;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_EXEC,
        BK_INS_SCAN,
        BK_DEL_READ,
        BK_CMP_SCAN,
        BK_CMP_WRITE
    } t_back_state;

endpackage

@@ rtl/core/stc_front.sv @@
// ----------------------------------------------------------------------------
// Slot table front end
// Accepts command beats, classifies them and pushes them into the queue.
// ----------------------------------------------------------------------------
module stc_front
    import stc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic i_start,
    input  t_cmd i_cmd,
    input  logic i_q_full,
    output logic o_push,
    output t_op  o_op,
    output logic o_busy
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int PW    = ((IDX_W > 4) ? IDX_W : 4) + 1;

    logic [PW-1:0]         pos_ext;
    logic                  pos_ok;
    logic [DATA_WIDTH-1:0] val_dw;

    assign o_busy  = i_q_full;
    assign o_push  = i_start && !i_q_full;
    assign pos_ext = PW'(i_cmd.position);
    assign pos_ok  = (pos_ext != '0) && (pos_ext <= PW'(SLOTS));
    // The empty test applies to the bits that would be stored.
    assign val_dw  = DATA_WIDTH'(i_cmd.value);

    always_comb begin
        o_op.value    = i_cmd.value;
        o_op.position = i_cmd.position;
        unique case (i_cmd.command)
            CMD_INSERT:  o_op.kind = (val_dw == '0) ? OP_INSERT_ZERO : OP_INSERT;
            CMD_DELETE:  o_op.kind = pos_ok ? OP_DELETE : OP_BAD_POS;
            CMD_COMPACT: o_op.kind = OP_COMPACT;
            default:     o_op.kind = OP_NOP;
        endcase
    end

endmodule

@@ rtl/core/stc_queue.sv @@
// ----------------------------------------------------------------------------
// Slot table operation queue
// Short FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module stc_queue
    import stc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    input  logic i_pop,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op
);

    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    t_op               r_buf [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic [PTR_W-1:0]  n_wr_ptr;
    logic [PTR_W-1:0]  n_rd_ptr;

    assign o_full  = (r_fill == FILL_W'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_op    = r_buf[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + 1'b1;
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/stc_back.sv @@
// ----------------------------------------------------------------------------
// Slot table back end
// Holds the slot memory and occupancy bits and carries out insert, delete
// and compaction one operation at a time.
// ----------------------------------------------------------------------------
module stc_back
    import stc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_op     i_q_op,
    output logic    o_q_pop,
    output logic    o_done,
    output t_result o_result
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int PW    = ((IDX_W > 4) ? IDX_W : 4) + 1;

    logic signed [DATA_WIDTH-1:0] r_mem [SLOTS];
    logic signed [DATA_WIDTH-1:0] r_rd_data;

    t_back_state      r_state;
    t_back_state      n_state;
    t_op              r_op;
    logic [SLOTS-1:0] r_occ;
    logic [SLOTS-1:0] n_occ;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] n_ptr;
    logic [IDX_W-1:0] r_dst;
    logic [IDX_W-1:0] n_dst;
    logic             r_done;
    t_result          r_result;

    logic                         mem_we;
    logic [IDX_W-1:0]             mem_waddr;
    logic signed [DATA_WIDTH-1:0] mem_wdata;
    logic                         mem_re;
    logic [IDX_W-1:0]             mem_raddr;
    logic                         emit;
    t_result                      emit_res;

    logic [PW-1:0]                pos_m1;
    logic [IDX_W-1:0]             del_idx;
    logic [IDX_W:0]               ptr_p1;
    logic                         table_full;
    logic                         cur_occ;
    logic                         ptr_at_dst;
    logic                         ptr_at_zero;
    logic signed [DATA_WIDTH-1:0] val_dw;

    assign pos_m1      = PW'(r_op.position) - PW'(1);
    assign del_idx     = pos_m1[IDX_W-1:0];
    assign ptr_p1      = {1'b0, r_ptr} + 1'b1;
    assign table_full  = (r_count == CW'(SLOTS));
    assign cur_occ     = r_occ[r_ptr];
    assign ptr_at_dst  = (r_ptr == r_dst);
    assign ptr_at_zero = (r_ptr == '0);
    assign val_dw      = DATA_WIDTH'(r_op.value);
    assign o_q_pop     = (r_state == BK_IDLE) && i_q_valid;
    assign o_done      = r_done;
    assign o_result    = r_result;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                unique case (r_op.kind) inside
                    OP_INSERT:  n_state = table_full ? BK_IDLE : BK_INS_SCAN;
                    OP_DELETE:  n_state = r_occ[del_idx] ? BK_DEL_READ : BK_IDLE;
                    OP_COMPACT: n_state = BK_CMP_SCAN;
                    default:    n_state = BK_IDLE;
                endcase
            end
            BK_INS_SCAN: begin
                if (!cur_occ) begin
                    n_state = BK_IDLE;
                end
            end
            BK_DEL_READ: begin
                n_state = BK_IDLE;
            end
            BK_CMP_SCAN: begin
                if (cur_occ && !ptr_at_dst) begin
                    n_state = BK_CMP_WRITE;
                end else if (ptr_at_zero) begin
                    n_state = BK_IDLE;
                end
            end
            BK_CMP_WRITE: begin
                n_state = ptr_at_zero ? BK_IDLE : BK_CMP_SCAN;
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    // Outputs and datapath next values.
    always_comb begin
        n_occ     = r_occ;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_dst     = r_dst;
        mem_we    = 1'b0;
        mem_waddr = r_ptr;
        mem_wdata = val_dw;
        mem_re    = 1'b0;
        mem_raddr = r_ptr;
        emit      = 1'b0;
        emit_res.status        = ST_OK;
        emit_res.removed_value = '0;
        emit_res.slot_used     = '0;
        unique case (r_state)
            BK_IDLE: begin
            end
            BK_EXEC: begin
                unique case (r_op.kind) inside
                    OP_INSERT: begin
                        if (table_full) begin
                            emit            = 1'b1;
                            emit_res.status = ST_FULL;
                        end else begin
                            n_ptr = '0;
                        end
                    end
                    OP_INSERT_ZERO: begin
                        emit            = 1'b1;
                        emit_res.status = table_full ? ST_FULL : ST_OK;
                    end
                    OP_DELETE: begin
                        if (r_occ[del_idx]) begin
                            mem_re    = 1'b1;
                            mem_raddr = del_idx;
                        end else begin
                            emit            = 1'b1;
                            emit_res.status = ST_EMPTY;
                        end
                    end
                    OP_BAD_POS: begin
                        emit            = 1'b1;
                        emit_res.status = ST_BAD_POS;
                    end
                    OP_COMPACT: begin
                        n_ptr = IDX_W'(SLOTS - 1);
                        n_dst = IDX_W'(SLOTS - 1);
                    end
                    default: begin
                        emit = 1'b1;
                    end
                endcase
            end
            BK_INS_SCAN: begin
                if (!cur_occ) begin
                    mem_we             = 1'b1;
                    n_occ[r_ptr]       = 1'b1;
                    n_count            = r_count + 1'b1;
                    emit               = 1'b1;
                    emit_res.slot_used = 4'(ptr_p1);
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            BK_DEL_READ: begin
                n_occ[del_idx]         = 1'b0;
                n_count                = r_count - 1'b1;
                emit                   = 1'b1;
                emit_res.removed_value = 32'(r_rd_data);
                emit_res.slot_used     = r_op.position;
            end
            BK_CMP_SCAN: begin
                // A value already sitting at the destination stays in place.
                if (cur_occ && !ptr_at_dst) begin
                    mem_re = 1'b1;
                end else begin
                    if (cur_occ) begin
                        n_dst = r_dst - 1'b1;
                    end
                    if (ptr_at_zero) begin
                        emit = 1'b1;
                    end else begin
                        n_ptr = r_ptr - 1'b1;
                    end
                end
            end
            BK_CMP_WRITE: begin
                mem_we       = 1'b1;
                mem_waddr    = r_dst;
                mem_wdata    = r_rd_data;
                n_occ[r_ptr] = 1'b0;
                n_occ[r_dst] = 1'b1;
                n_dst        = r_dst - 1'b1;
                if (ptr_at_zero) begin
                    emit = 1'b1;
                end else begin
                    n_ptr = r_ptr - 1'b1;
                end
            end
            default: begin
            end
        endcase
        emit_res.occupied_count = 4'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_op <= i_q_op;
        end
        if (emit) begin
            r_result <= emit_res;
        end
        r_ptr <= n_ptr;
        r_dst <= n_dst;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_occ   <= '0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            r_count <= n_count;
            r_done  <= emit;
        end
    end

endmodule

@@ rtl/core/slot_table_with_compaction_top.sv @@
// ----------------------------------------------------------------------------
// Slot table with compaction
// Table of signed slots with insert, delete by position and stable
// compaction toward the highest slot.
// ----------------------------------------------------------------------------
// Usage:
//   A command beat (i_cmd) is taken on a rising edge where start is high and
//   busy is low. busy is high while the two-entry command queue is full.
//   Each command yields one result beat on o_result, marked by o_done for
//   exactly one cycle; the receiver must take it then, it cannot stall.
//   Insert into a full table, insert of zero, bad position, delete of an
//   empty slot and an unused command finish without a slot scan. Insert
//   scans upward from slot 0 to the lowest empty slot; delete reads the
//   slot and frees it; compact scans every slot from the highest down and
//   moves each value that is not yet at its destination.
//   The back end runs one command at a time. Its slot scan, one slot per cycle
//   but held while compaction writes a moved value, goes through a single-port
//   slot memory and sets the rate; up to two further commands wait in the queue.
//   Reset clears all occupancy bits, so every slot reads as empty at once.
// ----------------------------------------------------------------------------
module slot_table_with_compaction_top
    import stc_pkg::*;
#(
    parameter int SLOTS      = SLOTS_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_cmd    i_cmd,
    output logic    o_done,
    output t_result o_result
);

    logic q_push;
    logic q_full;
    logic q_valid;
    logic q_pop;
    t_op  front_op;
    t_op  q_op;

    stc_front #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .i_start  (start),
        .i_cmd    (i_cmd),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_op     (front_op),
        .o_busy   (busy)
    );

    stc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op)
    );

    stc_back #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_op    (q_op),
        .o_q_pop   (q_pop),
        .o_done    (o_done),
        .o_result  (o_result)
    );

endmodule
